// File: design/kfsd_pkg.sv
package kfsd_pkg;

  // default skeleton size
  localparam int MAX_BONES_DEF = 256;

  // config register map (word index, byte address = 4 * index)
  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_BONE_COUNT  = 2'd0;
  localparam logic [1:0] REG_SCALE       = 2'd1;
  localparam logic [1:0] REG_TRANSLATION = 2'd2;

  // Q8.24 one
  localparam logic [31:0] FACTOR_ONE = 32'h0100_0000;

  // record kinds (out_tuser)
  localparam logic [2:0] KIND_INIT_KEY  = 3'd0;
  localparam logic [2:0] KIND_DELTA_KEY = 3'd1;
  localparam logic [2:0] KIND_FRAME     = 3'd2;
  localparam logic [2:0] KIND_END       = 3'd3;
  localparam logic [2:0] KIND_SKIP      = 3'd4;

  // key channels
  localparam logic [1:0] CH_SCALE = 2'd0;
  localparam logic [1:0] CH_ROT   = 2'd1;
  localparam logic [1:0] CH_TRANS = 2'd2;

  // record control from the parser to the output register
  typedef struct packed {
    logic        emit;
    logic        is_key;
    logic [2:0]  kind;
    logic [11:0] bone;
    logic [1:0]  ch;
    logic [15:0] key_frame;
    logic [15:0] next_frame;
  } rec_ctl_t;

endpackage

// File: design/kfsd_rot_scale.sv
// v * 2^24 / 32766, rounded to nearest, ties away from zero.
// Uses 2^24 = 512 * 32766 + 1024, so only a 26-bit remainder is divided;
// that quotient is estimated by >> 15 and fixed with one compare.
module kfsd_rot_scale (
  input  logic signed [15:0] val,
  output logic signed [47:0] res
);

  logic [16:0] v17;
  logic [16:0] mag;
  logic [26:0] rem_num;
  logic [11:0] q_est;
  logic [16:0] rem;
  logic [11:0] q_fix;
  logic [25:0] q_mag;

  always_comb begin
    v17     = {val[15], val};
    mag     = val[15] ? (~v17 + 17'd1) : v17;
    rem_num = {mag, 10'b0} + 27'd16383;
    q_est   = rem_num[26:15];
    rem     = {2'b0, rem_num[14:0]} + {4'b0, q_est, 1'b0};
    q_fix   = q_est + {11'b0, (rem >= 17'd32766)};
    q_mag   = {mag, 9'b0} + {14'b0, q_fix};
    res     = val[15] ? (48'sd0 - $signed({22'b0, q_mag})) : $signed({22'b0, q_mag});
  end

endmodule

// File: design/kfsd_comp.sv
// Component scaling for one key: three 16x32 multipliers for scale and
// translation, four constant dividers for rotation.
module kfsd_comp (
  input  logic [1:0]         ch,
  input  logic               is_key,
  input  logic [15:0]        c0,
  input  logic [15:0]        c1,
  input  logic [15:0]        c2,
  input  logic [15:0]        c3,      // word on the bus, last component
  input  logic [31:0]        scale_factor,
  input  logic [31:0]        translation_factor,
  output logic signed [47:0] comp_x,
  output logic signed [47:0] comp_y,
  output logic signed [47:0] comp_z,
  output logic signed [47:0] comp_w
);

  logic signed [31:0] factor;
  logic signed [47:0] px, py, pz;
  logic signed [47:0] rx, ry, rz, rw;

  assign factor = (ch == kfsd_pkg::CH_SCALE) ? $signed(scale_factor)
                                             : $signed(translation_factor);

  assign px = $signed(c0) * factor;
  assign py = $signed(c1) * factor;
  assign pz = $signed(c3) * factor;

  kfsd_rot_scale u_rot_x (.val(c0), .res(rx));
  kfsd_rot_scale u_rot_y (.val(c1), .res(ry));
  kfsd_rot_scale u_rot_z (.val(c2), .res(rz));
  kfsd_rot_scale u_rot_w (.val(c3), .res(rw));

  always_comb begin
    comp_x = '0;
    comp_y = '0;
    comp_z = '0;
    comp_w = '0;
    if (is_key) begin
      if (ch == kfsd_pkg::CH_ROT) begin
        comp_x = rx;
        comp_y = ry;
        comp_z = rz;
        comp_w = rw;
      end else begin
        comp_x = px;
        comp_y = py;
        comp_z = pz;
      end
    end
  end

endmodule

// File: design/kfsd_cfg_regs.sv
module kfsd_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [kfsd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [8:0]                bone_count,
  output logic [31:0]               scale_factor,
  output logic [31:0]               translation_factor
);

  logic [8:0]  bone_count_r;
  logic [31:0] scale_r;
  logic [31:0] trans_r;
  logic [1:0]  idx;
  logic        wr;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bone_count_r <= '0;
      scale_r      <= kfsd_pkg::FACTOR_ONE;
      trans_r      <= kfsd_pkg::FACTOR_ONE;
    end else if (wr) begin
      case (idx)
        kfsd_pkg::REG_BONE_COUNT:  bone_count_r <= pwdata[8:0];
        kfsd_pkg::REG_SCALE:       scale_r      <= pwdata;
        kfsd_pkg::REG_TRANSLATION: trans_r      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      kfsd_pkg::REG_BONE_COUNT:  prdata = {23'b0, bone_count_r};
      kfsd_pkg::REG_SCALE:       prdata = scale_r;
      kfsd_pkg::REG_TRANSLATION: prdata = trans_r;
      default:                   prdata = '0;
    endcase
  end

  assign bone_count         = bone_count_r;
  assign scale_factor       = scale_r;
  assign translation_factor = trans_r;

endmodule

// File: design/kfsd_parse.sv
// Stream parser: phase machine, key word counter, component buffer and
// bone presence flags. State moves only on step.
module kfsd_parse #(
  parameter int MAX_BONES = kfsd_pkg::MAX_BONES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [15:0]        word,
  input  logic               restart,
  input  logic [8:0]         bone_count,
  output kfsd_pkg::rec_ctl_t rec,
  output logic [15:0]        cbuf0,
  output logic [15:0]        cbuf1,
  output logic [15:0]        cbuf2
);

  localparam int BIW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam logic [15:0] MB16 = 16'(MAX_BONES);
  localparam logic [15:0] WORD_LIST_END = 16'hFFFE;
  localparam logic [15:0] WORD_ABORT    = 16'hFFFF;

  typedef enum logic [5:0] {
    PH_IDLE        = 6'b000001,
    PH_INIT_ID     = 6'b000010,
    PH_INIT_DATA   = 6'b000100,
    PH_FIRST_FRAME = 6'b001000,
    PH_HEADER      = 6'b010000,
    PH_KEY         = 6'b100000
  } phase_t;

  phase_t                 phase_r, phase_nxt, ph;
  logic [2:0]             widx_r, widx_nxt;
  logic [2:0]             pend_r, pend_nxt;
  logic [11:0]            bone_r, bone_nxt;
  logic                   skip_r, skip_nxt;
  logic [15:0]            held_r, held_nxt;
  logic [15:0]            cbuf_r [3];
  logic                   cbuf_we;
  logic [1:0]             cbuf_sel;
  logic [MAX_BONES-1:0]   present_r, present_nxt;

  logic [15:0]            hdr_b16;
  logic                   hdr_ok;
  logic                   is_init;
  logic [1:0]             ch;
  logic [2:0]             n_words;
  logic [2:0]             ch_bit;
  logic                   is_frame;
  logic [15:0]            frame_val;
  logic [BIW-1:0]         idx_init;
  logic [BIW-1:0]         idx_hdr;

  function automatic logic id_ok(input logic [15:0] val, input logic [8:0] cnt);
    id_ok = !val[15] && (val < {7'b0, cnt}) && (val < MB16);
  endfunction

  always_comb begin
    ph          = restart ? PH_INIT_ID : phase_r;
    phase_nxt   = ph;
    widx_nxt    = widx_r;
    pend_nxt    = pend_r;
    bone_nxt    = bone_r;
    skip_nxt    = skip_r;
    held_nxt    = held_r;
    present_nxt = restart ? '0 : present_r;
    cbuf_we     = 1'b0;
    cbuf_sel    = widx_r[1:0] - 2'd1;
    rec         = '0;
    is_frame    = 1'b0;
    frame_val   = word;

    hdr_b16  = {{4{word[15]}}, word[15:4]};
    idx_init = word[BIW-1:0];
    idx_hdr  = hdr_b16[BIW-1:0];
    hdr_ok   = id_ok(hdr_b16, bone_count) && present_r[idx_hdr];

    is_init = (ph == PH_INIT_DATA);
    ch      = pend_r[2] ? kfsd_pkg::CH_SCALE :
              (pend_r[1] ? kfsd_pkg::CH_ROT : kfsd_pkg::CH_TRANS);
    n_words = (ch == kfsd_pkg::CH_ROT) ? 3'd4 : 3'd3;
    ch_bit  = 3'b100 >> ch;

    case (ph)
      PH_INIT_ID: begin
        if (word == WORD_LIST_END) begin
          phase_nxt = PH_FIRST_FRAME;
        end else begin
          skip_nxt = !id_ok(word, bone_count);
          if (id_ok(word, bone_count)) begin
            present_nxt[idx_init] = 1'b1;
          end
          bone_nxt  = word[11:0];
          pend_nxt  = 3'b111;
          widx_nxt  = 3'd1;
          held_nxt  = '0;
          phase_nxt = PH_INIT_DATA;
        end
      end
      PH_FIRST_FRAME: begin
        is_frame = 1'b1;
      end
      PH_HEADER: begin
        if (word[0]) begin
          bone_nxt = word[15:4];
          skip_nxt = !hdr_ok;
          pend_nxt = word[3:1];
          widx_nxt = 3'd0;
          if (word[3:1] != 3'd0) begin
            phase_nxt = PH_KEY;
          end
          if (!hdr_ok) begin
            rec.emit = 1'b1;
            rec.kind = kfsd_pkg::KIND_SKIP;
            rec.bone = word[15:4];
          end
        end else begin
          is_frame  = 1'b1;
          frame_val = {word[15], word[15:1]};
        end
      end
      PH_INIT_DATA, PH_KEY: begin
        if (pend_r == 3'd0) begin
          phase_nxt = is_init ? PH_INIT_ID : PH_HEADER;
        end else if (widx_r == 3'd0) begin
          held_nxt = word;
          widx_nxt = 3'd1;
        end else if (widx_r < n_words) begin
          cbuf_we  = 1'b1;
          widx_nxt = widx_r + 3'd1;
        end else begin
          pend_nxt = pend_r & ~ch_bit;
          widx_nxt = is_init ? 3'd1 : 3'd0;
          if ((pend_r & ~ch_bit) == 3'd0) begin
            phase_nxt = is_init ? PH_INIT_ID : PH_HEADER;
          end
          rec.emit      = !skip_r;
          rec.is_key    = 1'b1;
          rec.kind      = is_init ? kfsd_pkg::KIND_INIT_KEY : kfsd_pkg::KIND_DELTA_KEY;
          rec.bone      = bone_r;
          rec.ch        = ch;
          rec.key_frame = is_init ? 16'd0 : held_r;
        end
      end
      default: ;
    endcase

    // frame id: -1 and -2 end the stream
    if (is_frame) begin
      rec.emit       = 1'b1;
      rec.next_frame = frame_val;
      if (frame_val == WORD_ABORT || frame_val == WORD_LIST_END) begin
        rec.kind  = kfsd_pkg::KIND_END;
        phase_nxt = PH_IDLE;
      end else begin
        rec.kind  = kfsd_pkg::KIND_FRAME;
        phase_nxt = PH_HEADER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      widx_r    <= '0;
      pend_r    <= '0;
      bone_r    <= '0;
      skip_r    <= 1'b0;
      present_r <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      widx_r    <= widx_nxt;
      pend_r    <= pend_nxt;
      bone_r    <= bone_nxt;
      skip_r    <= skip_nxt;
      present_r <= present_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      held_r <= held_nxt;
      if (cbuf_we) begin
        cbuf_r[cbuf_sel] <= word;
      end
    end
  end

  assign cbuf0 = cbuf_r[0];
  assign cbuf1 = cbuf_r[1];
  assign cbuf2 = cbuf_r[2];

endmodule

// File: design/keyframe_stream_decoder_core.sv
// Key-frame stream decoder. Takes 16-bit stream words and returns at most
// one record per word: initial keys, delta keys, frame ids, end of stream
// and skipped chunks. A word is held in the input register and its record
// is registered in the output register that drives out_tdata; the
// sustained rate is one word per clock as long as out_tready stays high.
// A word that makes no record moves on even while the output register
// holds an untaken record; a word that makes a record waits only for that
// register to free up. Scale and translation components go through 16x32
// multipliers, rotation components through a constant 1/32766 divider
// (reciprocal trick plus one correction), all combinational between the
// two registers. Bone presence lives in a MAX_BONES-bit flop vector that
// reset and every restart word clear at once, so there is no clearing pass.
// Registers are to be written over the APB-style port only while the stream
// is idle; the block itself does not enforce this.
module keyframe_stream_decoder_core #(
  parameter int MAX_BONES = kfsd_pkg::MAX_BONES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // [15:0] word
  input  logic [0:0]                  in_tuser,   // [0] restart
  // record stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [11:0] bone_id, [13:12] channel, [29:14] key_frame, [77:30] comp_x,
  // [125:78] comp_y, [173:126] comp_z, [221:174] comp_w,
  // [237:222] next_frame, [239:238] zero
  output logic [239:0]                out_tdata,
  output logic [2:0]                  out_tuser,  // [2:0] record_kind
  // config port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [kfsd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  // input register
  logic        in_valid_r;
  logic [15:0] in_word_r;
  logic        in_restart_r;

  // output register
  logic         out_valid_r;
  logic [239:0] out_tdata_r, out_tdata_nxt;
  logic [2:0]   out_tuser_r;

  logic        out_free;
  logic        adv;

  logic [8:0]  bone_count;
  logic [31:0] scale_factor;
  logic [31:0] translation_factor;

  kfsd_pkg::rec_ctl_t rec;
  logic [15:0] cbuf0, cbuf1, cbuf2;
  logic signed [47:0] comp_x, comp_y, comp_z, comp_w;

  kfsd_cfg_regs u_cfg (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (cfg_psel),
    .penable            (cfg_penable),
    .pwrite             (cfg_pwrite),
    .paddr              (cfg_paddr),
    .pwdata             (cfg_pwdata),
    .prdata             (cfg_prdata),
    .pready             (cfg_pready),
    .bone_count         (bone_count),
    .scale_factor       (scale_factor),
    .translation_factor (translation_factor)
  );

  // a word leaves the input register when it makes no record, or when
  // the output register is empty or being drained this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign adv       = in_valid_r && (!rec.emit || out_free);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_word_r    <= in_tdata;
      in_restart_r <= in_tuser[0];
    end
  end

  kfsd_parse #(
    .MAX_BONES (MAX_BONES)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .word       (in_word_r),
    .restart    (in_restart_r),
    .bone_count (bone_count),
    .rec        (rec),
    .cbuf0      (cbuf0),
    .cbuf1      (cbuf1),
    .cbuf2      (cbuf2)
  );

  kfsd_comp u_comp (
    .ch                 (rec.ch),
    .is_key             (rec.is_key),
    .c0                 (cbuf0),
    .c1                 (cbuf1),
    .c2                 (cbuf2),
    .c3                 (in_word_r),
    .scale_factor       (scale_factor),
    .translation_factor (translation_factor),
    .comp_x             (comp_x),
    .comp_y             (comp_y),
    .comp_z             (comp_z),
    .comp_w             (comp_w)
  );

  assign out_tdata_nxt = {2'b0, rec.next_frame, comp_w, comp_z, comp_y, comp_x,
                          rec.key_frame, rec.ch, rec.bone};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && rec.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && rec.emit) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= rec.kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef ASSERT_OFF
  // end-of-stream records only ever carry frame id -1 or -2
  a_end_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == kfsd_pkg::KIND_END) |->
      (out_tdata[237:222] == 16'hFFFF || out_tdata[237:222] == 16'hFFFE))
    else $error("end record with bad frame id");

  // frame, end and skip records carry no components
  a_nonkey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == kfsd_pkg::KIND_FRAME || out_tuser == kfsd_pkg::KIND_END ||
                    out_tuser == kfsd_pkg::KIND_SKIP)) |->
      (out_tdata[221:30] == '0))
    else $error("non-key record with components");

  // initial keys are frame 0, key records name a real channel
  a_key_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && rec.emit && rec.is_key) |=>
      (out_tdata[13:12] != 2'd3 &&
       (out_tuser != kfsd_pkg::KIND_INIT_KEY || out_tdata[29:14] == 16'd0)))
    else $error("bad key record fields");
`endif

endmodule
